@@ rtl/srcnt_pkg.sv @@
// srcnt_pkg: shared constants and types for the sorted range count block
// store depth, index widths and operation codes; no dependencies
`default_nettype none

package srcnt_pkg;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned IN_TDATA_W  = 3 * VALUE_W;
  localparam int unsigned OUT_TDATA_W = ((COUNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [IDX_W-1:0]          idx_t;

endpackage : srcnt_pkg

`default_nettype wire

@@ rtl/sorted_range_count.sv @@
// sorted_range_count: sorted store of signed values with inclusive range-count queries
// one memory with a registered read port, one shared signed comparator, small sequencer; uses srcnt_pkg
// clear, unused code or load into a full store go straight to the response; a query runs a lower bound
// search then an upper bound search; a load searches, moves each stored value above the new one up one,
// then writes it; each search has <= 11 binary steps at 1024, each a read port access then a comparison
// one item at a time, next taken in the cycle its result is presented; reset clears state, count, m_valid
`default_nettype none

module sorted_range_count (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // value [31:0], range_low [63:32], range_high [95:64]
  input  wire logic [srcnt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // opcode [1:0]
  input  wire logic [1:0]                         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // count [10:0], zero padding above
  output logic [srcnt_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // status [0]
  output logic                                    m_axis_tuser
);
  import srcnt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       op_q, op_d;
  value_t           val_q, val_d;
  value_t           high_q, high_d;
  value_t           key_q, key_d;
  logic             above_q, above_d;
  logic             second_q, second_d;
  idx_t             lo_q, lo_d;
  idx_t             hi_q, hi_d;
  idx_t             mid_q, mid_d;
  idx_t             lo_idx_q, lo_idx_d;
  idx_t             pos_q, pos_d;
  idx_t             shift_q, shift_d;
  idx_t             cnt_q, cnt_d;
  logic [COUNT_W-1:0] res_count_q, res_count_d;
  logic             res_status_q, res_status_d;
  logic             m_valid_q, m_valid_d;
  logic [COUNT_W-1:0] m_count_q, m_count_d;
  logic             m_status_q, m_status_d;

  // store memory
  logic [VALUE_W-1:0] mem [STORE_DEPTH];
  logic [VALUE_W-1:0] rd_data_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // shared comparator: stored value against search key
  logic cmp_gt, cmp_eq, cmp_hit;
  assign cmp_gt  = $signed(rd_data_q) > key_q;
  assign cmp_eq  = rd_data_q == key_q;
  assign cmp_hit = above_q ? cmp_gt : (cmp_gt | cmp_eq);

  idx_t span;
  assign span = hi_q - lo_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_count_q);
  assign m_axis_tuser  = m_status_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    val_d        = val_q;
    high_d       = high_q;
    key_d        = key_q;
    above_d      = above_q;
    second_d     = second_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    lo_idx_d     = lo_idx_q;
    pos_d        = pos_q;
    shift_d      = shift_q;
    cnt_d        = cnt_q;
    res_count_d  = res_count_q;
    res_status_d = res_status_q;
    m_valid_d    = m_valid_q;
    m_count_d    = m_count_q;
    m_status_d   = m_status_q;
    mem_we       = 1'b0;
    mem_waddr    = shift_q[ADDR_W-1:0];
    mem_wdata    = rd_data_q;
    mem_re       = 1'b0;
    mem_raddr    = mid_q[ADDR_W-1:0];

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d         = s_axis_tuser;
          val_d        = value_t'(s_axis_tdata[VALUE_W-1:0]);
          high_d       = value_t'(s_axis_tdata[3*VALUE_W-1:2*VALUE_W]);
          lo_d         = '0;
          hi_d         = cnt_q;
          second_d     = 1'b0;
          res_count_d  = '0;
          res_status_d = 1'b0;
          state_d      = ST_RESP;
          case (s_axis_tuser)
            OP_CLEAR: begin
              cnt_d = '0;
            end
            OP_LOAD: begin
              if (cnt_q >= idx_t'(STORE_DEPTH)) begin
                res_count_d  = COUNT_W'(cnt_q);
                res_status_d = 1'b1;
              end else begin
                key_d   = value_t'(s_axis_tdata[VALUE_W-1:0]);
                above_d = 1'b1;
                state_d = ST_SRCH_RD;
              end
            end
            OP_QUERY: begin
              key_d   = value_t'(s_axis_tdata[2*VALUE_W-1:VALUE_W]);
              above_d = 1'b0;
              state_d = ST_SRCH_RD;
            end
            default: ;
          endcase
        end
      end

      ST_SRCH_RD: begin
        if (lo_q < hi_q) begin
          mid_d     = lo_q + (span >> 1);
          mem_re    = 1'b1;
          mem_raddr = mid_d[ADDR_W-1:0];
          state_d   = ST_SRCH_CMP;
        end else if (op_q == OP_LOAD) begin
          pos_d   = lo_q;
          shift_d = cnt_q;
          state_d = ST_SHIFT_RD;
        end else if (!second_q) begin
          // lower bound found, start the upper bound search
          lo_idx_d = lo_q;
          key_d    = high_q;
          above_d  = 1'b1;
          second_d = 1'b1;
          lo_d     = '0;
          hi_d     = cnt_q;
        end else begin
          res_count_d = (lo_q > lo_idx_q) ? COUNT_W'(lo_q - lo_idx_q) : '0;
          state_d     = ST_RESP;
        end
      end

      ST_SRCH_CMP: begin
        if (cmp_hit) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + idx_t'(1);
        end
        state_d = ST_SRCH_RD;
      end

      ST_SHIFT_RD: begin
        if (shift_q > pos_q) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(shift_q - idx_t'(1));
          state_d   = ST_SHIFT_WR;
        end else begin
          state_d = ST_INSERT;
        end
      end

      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = shift_q[ADDR_W-1:0];
        mem_wdata = rd_data_q;
        shift_d   = shift_q - idx_t'(1);
        state_d   = ST_SHIFT_RD;
      end

      ST_INSERT: begin
        mem_we      = 1'b1;
        mem_waddr   = pos_q[ADDR_W-1:0];
        mem_wdata   = val_q;
        cnt_d       = cnt_q + idx_t'(1);
        res_count_d = COUNT_W'(cnt_q + idx_t'(1));
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        // hand the item over once the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_count_d  = res_count_q;
          m_status_d = res_status_q;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    high_q       <= high_d;
    key_q        <= key_d;
    above_q      <= above_d;
    second_q     <= second_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    lo_idx_q     <= lo_idx_d;
    pos_q        <= pos_d;
    shift_q      <= shift_d;
    res_count_q  <= res_count_d;
    res_status_q <= res_status_d;
    m_count_q    <= m_count_d;
    m_status_q   <= m_status_d;
  end

endmodule : sorted_range_count

`default_nettype wire
